// ===== rtl/hufd_pkg.sv =====
package hufd_pkg;

    localparam int MAX_NODES = 1024;
    localparam int ADDR_W    = $clog2(MAX_NODES);

    localparam int LINK_W    = 11;
    localparam int GLYPH_W   = 9;
    localparam int COUNT_W   = 11;
    localparam int INDEX_W   = 10;
    localparam int BYTE_W    = 8;
    localparam int BITCNT_W  = $clog2(BYTE_W);

    localparam logic [LINK_W-1:0]  LINK_NONE = '1;
    localparam logic [GLYPH_W-1:0] GLYPH_END = 9'd256;
    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 11'd1;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_DECODE = 2'd1,
        ACT_START  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_SYMBOL = 2'd0,
        ST_END    = 2'd1,
        ST_ERROR  = 2'd2
    } t_status;

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic [LINK_W-1:0]  left;
        logic [LINK_W-1:0]  right;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic    accept;
        logic    rd_cur;
        logic    rd_link;
        logic    rd_root;
        logic    ld_entry;
        logic    go_root;
        logic    advance;
        logic    emit;
        t_status emit_code;
        logic    flush;
    } t_dp_cmd;

    typedef struct packed {
        logic link_bad;
        logic is_leaf;
        logic is_end;
        logic bit_last;
        logic halted;
        logic end_seen;
        logic err_seen;
        logic pend_valid;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/hufd_intf.sv =====
interface hufd_in_if import hufd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [1:0]                action;
    logic [INDEX_W-1:0]        node_index;
    logic [GLYPH_W-1:0]        node_glyph;
    logic signed [LINK_W-1:0]  node_left;
    logic signed [LINK_W-1:0]  node_right;
    logic [BYTE_W-1:0]         data_byte;

    modport source (output valid, action, node_index, node_glyph, node_left, node_right,
                    data_byte, input ready);
    modport sink (input valid, action, node_index, node_glyph, node_left, node_right,
                  data_byte, output ready);
endinterface

interface hufd_out_if import hufd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [BYTE_W-1:0] symbol;
    logic              last;

    modport source (output valid, status, symbol, last, input ready);
    modport sink (input valid, status, symbol, last, output ready);
endinterface

interface hufd_cfg_if import hufd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== rtl/hufd_ram.sv =====
module hufd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/hufd_dp.sv =====
module hufd_dp import hufd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic [1:0]               i_action,
    input  logic [INDEX_W-1:0]       i_node_index,
    input  logic [GLYPH_W-1:0]       i_node_glyph,
    input  logic signed [LINK_W-1:0] i_node_left,
    input  logic signed [LINK_W-1:0] i_node_right,
    input  logic [BYTE_W-1:0]        i_data_byte,
    input  logic                     i_cfg_valid,
    input  logic [COUNT_W-1:0]       i_cfg_data,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic [1:0]               o_out_status,
    output logic [BYTE_W-1:0]        o_out_symbol,
    output logic                     o_out_last
);

    logic [COUNT_W-1:0]  r_node_count;
    logic [ADDR_W-1:0]   r_cur_node;
    logic                r_end;
    logic                r_err;
    t_entry              r_entry;
    logic [BYTE_W-1:0]   r_bits;
    logic [BITCNT_W-1:0] r_bit_cnt;
    logic                r_pend_valid;
    t_status             r_pend_status;
    logic [BYTE_W-1:0]   r_pend_symbol;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [BYTE_W-1:0]   r_out_symbol;
    logic                r_out_last;

    logic [LINK_W-1:0]   link;
    logic                wr_en;
    t_entry              wr_entry;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    t_entry              rd_entry;
    logic                out_free;
    logic                push;
    logic [BYTE_W-1:0]   new_symbol;

    assign link = r_bits[0] ? r_entry.right : r_entry.left;

    assign wr_en    = i_cmd.accept && (i_action == ACT_WRITE)
                      && (32'(i_node_index) < MAX_NODES);
    assign wr_entry = '{glyph: i_node_glyph, left: $unsigned(i_node_left),
                        right: $unsigned(i_node_right)};

    assign rd_en   = i_cmd.rd_cur || i_cmd.rd_link || i_cmd.rd_root;
    assign rd_addr = i_cmd.rd_link ? ADDR_W'(link) :
                     i_cmd.rd_cur  ? r_cur_node    : '0;

    hufd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (ADDR_W'(i_node_index)),
        .i_wr_data (wr_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_entry)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign push       = r_pend_valid && (i_cmd.emit || i_cmd.flush);
    assign new_symbol = (i_cmd.emit_code == ST_SYMBOL) ? rd_entry.glyph[BYTE_W-1:0] : '0;

    always_comb begin
        o_stat.link_bad   = link[LINK_W-1] || (link >= r_node_count)
                            || (32'(link) >= MAX_NODES);
        o_stat.is_leaf    = (rd_entry.left == LINK_NONE) && (rd_entry.right == LINK_NONE);
        o_stat.is_end     = rd_entry.glyph == GLYPH_END;
        o_stat.bit_last   = r_bit_cnt == BITCNT_W'(BYTE_W - 1);
        o_stat.halted     = r_end || r_err;
        o_stat.end_seen   = r_end;
        o_stat.err_seen   = r_err;
        o_stat.pend_valid = r_pend_valid;
        o_stat.out_free   = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RESET;
            r_cur_node   <= '0;
            r_end        <= 1'b0;
            r_err        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_bit_cnt    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_node_count <= i_cfg_data;
            end
            if (i_cmd.accept && (i_action == ACT_START)) begin
                r_cur_node <= '0;
                r_end      <= 1'b0;
                r_err      <= 1'b0;
            end else if (i_cmd.rd_link) begin
                r_cur_node <= ADDR_W'(link);
            end else if (i_cmd.go_root) begin
                r_cur_node <= '0;
            end
            if (i_cmd.emit && (i_cmd.emit_code == ST_END)) begin
                r_end <= 1'b1;
            end
            if (i_cmd.emit && (i_cmd.emit_code == ST_ERROR)) begin
                r_err <= 1'b1;
            end
            if (i_cmd.accept) begin
                r_bit_cnt <= '0;
            end else if (i_cmd.advance) begin
                r_bit_cnt <= r_bit_cnt + 1'b1;
            end
            if (i_cmd.emit) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_entry) begin
            r_entry <= rd_entry;
        end
        if (i_cmd.accept) begin
            r_bits <= i_data_byte;
        end else if (i_cmd.advance) begin
            r_bits <= r_bits >> 1;
        end
        if (i_cmd.emit) begin
            r_pend_status <= i_cmd.emit_code;
            r_pend_symbol <= new_symbol;
        end
        if (push) begin
            r_out_status <= r_pend_status;
            r_out_symbol <= r_pend_symbol;
            r_out_last   <= i_cmd.flush;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_symbol = r_out_symbol;
    assign o_out_last   = r_out_last;

endmodule

// ===== rtl/hufd_ctrl.sv =====
module hufd_ctrl import hufd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_action,
    input  t_dp_stat   i_stat,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_STEP  = 5'b00100,
        S_NEXT  = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   can_emit;

    // a new result may enter the pending slot once the older one can move on
    assign can_emit   = !i_stat.pend_valid || i_stat.out_free;
    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if ((i_action == ACT_DECODE) && !i_stat.halted) begin
                        o_cmd.rd_cur = 1'b1;
                        n_state      = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.ld_entry = 1'b1;
                n_state        = S_STEP;
            end
            S_STEP: begin
                if (i_stat.link_bad) begin
                    if (can_emit) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_code = ST_ERROR;
                        n_state         = S_FLUSH;
                    end
                end else begin
                    o_cmd.rd_link = 1'b1;
                    n_state       = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_stat.is_leaf) begin
                    if (can_emit) begin
                        o_cmd.emit = 1'b1;
                        if (i_stat.is_end) begin
                            o_cmd.emit_code = ST_END;
                            n_state         = S_FLUSH;
                        end else begin
                            o_cmd.emit_code = ST_SYMBOL;
                            o_cmd.go_root   = 1'b1;
                            if (i_stat.bit_last) begin
                                n_state = S_FLUSH;
                            end else begin
                                o_cmd.advance = 1'b1;
                                o_cmd.rd_root = 1'b1;
                                n_state       = S_LOAD;
                            end
                        end
                    end
                end else begin
                    o_cmd.ld_entry = 1'b1;
                    if (i_stat.bit_last) begin
                        n_state = S_FLUSH;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_STEP;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_stat.pend_valid || i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/huffman_table_bit_decoder.sv =====
// Channel   Dir  Handshake      Payload
// i_in      in   valid / ready  action, node_index, node_glyph, node_left, node_right, data_byte
// o_out     out  valid / ready  status, symbol, last
// i_cfg     in   valid / ready  data (node_count), ready tied high
//
// A node write, start or unused item is taken while idle and needs no further step. A data
// byte runs: accept, current-node fetch, a link check and child read per code bit,
// and a close step; each symbol before the last bit adds a root refetch.
// An end or bad link closes the byte early; a byte after a halt is taken and dropped.
// Reset: walk to the root, flags cleared, node_count 1; the node table keeps its contents.
// A stalled o_out holds the walk only once the pending slot and output register are full.
module huffman_table_bit_decoder import hufd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hufd_in_if.sink     i_in,
    hufd_out_if.source  o_out,
    hufd_cfg_if.sink    i_cfg
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;

    // node_count must only be written while idle (the block does not enforce this), so take every transfer at once
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;

    hufd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_action   (i_in.action),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // datapath: node RAM, walk registers, pending slot and output register
    hufd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_action     (i_in.action),
        .i_node_index (i_in.node_index),
        .i_node_glyph (i_in.node_glyph),
        .i_node_left  (i_in.node_left),
        .i_node_right (i_in.node_right),
        .i_data_byte  (i_in.data_byte),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_data   (i_cfg.data),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_out_status (o_out.status),
        .o_out_symbol (o_out.symbol),
        .o_out_last   (o_out.last)
    );

    // decoding halts on the first end or error, so both can never be set
    a_halt_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stat.end_seen && stat.err_seen))
        else $error("end and error flags both set");

    // every result of a byte has left the pending slot before the next item is taken
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready |-> !stat.pend_valid)
        else $error("pending result left behind while idle");

    // a queued result must never overwrite an undelivered one
    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!stat.pend_valid || stat.out_free))
        else $error("result emitted with no room to move the pending one");

    // a start transfer reopens decoding
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && in_ready && (i_in.action == ACT_START)) |=> !stat.halted)
        else $error("start transfer did not clear the halt flags");

endmodule
